// ----- rtl/ece_pkg.sv -----
// Shared types and constants for the easing curve evaluator.
package ece_pkg;

  localparam int PROGRESS_W      = 32;
  localparam int EASED_W         = 17;
  localparam int CURVE_W         = 3;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [CURVE_W-1:0] {
    CRV_LINEAR      = 3'd0,
    CRV_IN_QUAD     = 3'd1,
    CRV_OUT_QUAD    = 3'd2,
    CRV_INOUT_QUAD  = 3'd3,
    CRV_IN_CUBIC    = 3'd4,
    CRV_OUT_CUBIC   = 3'd5,
    CRV_INOUT_CUBIC = 3'd6,
    CRV_BOUNCE      = 3'd7
  } curve_t;

  // Work the back end does on one beat.
  typedef enum logic [2:0] {
    OP_LIN   = 3'd0,  // pass operand through
    OP_SQ    = 3'd1,  // round(x*x)
    OP_SQ2   = 3'd2,  // round(2*x*x)
    OP_CUBE  = 3'd3,  // round(round(x*x)*x)
    OP_CUBE4 = 3'd4,  // round(4*round(x*x)*x)
    OP_BNC   = 3'd5   // round(m*m/64) plus segment base
  } op_t;

  typedef struct packed {
    op_t  op;
    logic sub;        // result is ONE minus the value
  } ctl_t;

endpackage

// ----- rtl/easing_curve_evaluator_top.sv -----
// Top level of the easing curve evaluator: front end, queue and back end.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+--------------------------------
//   in       | in_valid / in_stall     | progress  signed Q15.16
//   out      | out_valid / out_stall   | eased     unsigned Q1.16
//   cfg      | cfg_valid / cfg_ready   | curve     3-bit curve select
//
// One beat per cycle sustained while out_stall stays low; an accepted input
// beat passes the front register, a queue slot and four back-end stages.
// The back end holds while its output beat is stalled; the queue keeps taking
// input beats until it fills, then in_stall rises.
// Reset clears the curve select to linear and empties the pipeline and queue.
module easing_curve_evaluator_top #(
  parameter int FRAC_BITS   = ece_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = ece_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ece_pkg::PROGRESS_W-1:0]  progress,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ece_pkg::EASED_W-1:0]     eased,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ece_pkg::CURVE_W-1:0]     curve
);
  import ece_pkg::*;

  localparam int XW = FRAC_BITS + 4;
  localparam int BW = FRAC_BITS + 1;
  localparam int QW = $bits(ctl_t) + XW + BW;

  logic            push;
  logic            full;
  ctl_t            push_ctl;
  logic [XW-1:0]   push_x;
  logic [BW-1:0]   push_base;
  logic            pop;
  logic            nonempty;
  logic [QW-1:0]   rdata;
  ctl_t            pop_ctl;
  logic [XW-1:0]   pop_x;
  logic [BW-1:0]   pop_base;

  ece_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .progress  (progress),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .curve     (curve),
    .push      (push),
    .full      (full),
    .push_ctl  (push_ctl),
    .push_x    (push_x),
    .push_base (push_base)
  );

  ece_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    ({push_ctl, push_x, push_base}),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .rdata    (rdata)
  );

  assign pop_ctl  = ctl_t'(rdata[QW-1 -: $bits(ctl_t)]);
  assign pop_x    = rdata[BW +: XW];
  assign pop_base = rdata[BW-1:0];

  ece_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (nonempty),
    .pop       (pop),
    .pop_ctl   (pop_ctl),
    .pop_x     (pop_x),
    .pop_base  (pop_base),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .eased     (eased)
  );

endmodule

// ----- rtl/ece_front.sv -----
// Front end: input beat acceptance, clamp, curve register and classification.
module ece_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ece_pkg::PROGRESS_W-1:0]  progress,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ece_pkg::CURVE_W-1:0]     curve,
  output logic                            push,
  input  logic                            full,
  output ece_pkg::ctl_t                   push_ctl,
  output logic [FRAC_BITS+3:0]            push_x,
  output logic [FRAC_BITS:0]              push_base
);
  import ece_pkg::*;

  localparam int F = FRAC_BITS;
  localparam logic [F:0]   ONE  = {1'b1, {F{1'b0}}};
  localparam logic [F:0]   HALF = ONE >> 1;
  localparam logic [F+4:0] K4   = (F+5)'(4) << F;
  localparam logic [F+4:0] K8   = (F+5)'(8) << F;
  localparam logic [F+4:0] K10  = (F+5)'(10) << F;
  localparam logic [F+6:0] C12  = (F+7)'(12) << F;
  localparam logic [F+6:0] C18  = (F+7)'(18) << F;
  localparam logic [F+6:0] C21  = (F+7)'(21) << F;
  localparam logic [F:0]   B1   = (F+1)'(3) << (F-2);
  localparam logic [F:0]   B2   = (F+1)'(15) << (F-4);
  localparam logic [F:0]   B3   = (F+1)'(63) << (F-6);

  curve_t               curve_q;
  logic                 f_valid;
  logic [F:0]           f_t;
  logic [F:0]           t_next;
  logic                 advance;
  logic [F:0]           u;
  logic                 low_half;
  logic [F+4:0]         t11;
  logic [F+6:0]         cval;
  logic signed [F+6:0]  d;
  logic [F+6:0]         m;
  logic [F:0]           seg_base;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_q <= CRV_LINEAR;
    end else if (cfg_valid && cfg_ready) begin
      curve_q <= curve_t'(curve);
    end
  end

  assign push     = f_valid && !full;
  assign advance  = !f_valid || !full;
  assign in_stall = !advance;

  // Clamp to [0, ONE].
  always_comb begin
    if (progress[PROGRESS_W-1]) begin
      t_next = '0;
    end else if (progress > PROGRESS_W'(ONE)) begin
      t_next = ONE;
    end else begin
      t_next = progress[F:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (advance) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      f_t <= t_next;
    end
  end

  assign u        = ONE - f_t;
  assign low_half = f_t < HALF;
  assign t11      = ({4'b0, f_t} << 3) + ({4'b0, f_t} << 1) + {4'b0, f_t};

  // Bounce segment: split at 4/11, 8/11, 10/11, compared exactly on 11*T.
  always_comb begin
    if (t11 < K4) begin
      cval     = '0;
      seg_base = '0;
    end else if (t11 < K8) begin
      cval     = C12;
      seg_base = B1;
    end else if (t11 < K10) begin
      cval     = C18;
      seg_base = B2;
    end else begin
      cval     = C21;
      seg_base = B3;
    end
  end

  assign d = $signed({1'b0, t11, 1'b0}) - $signed(cval);
  assign m = d[F+6] ? (F+7)'(-d) : (F+7)'(d);

  always_comb begin
    push_ctl.op  = OP_LIN;
    push_ctl.sub = 1'b0;
    push_x       = (F+4)'(f_t);
    push_base    = '0;
    case (curve_q)
      CRV_LINEAR: begin
        push_ctl.op = OP_LIN;
      end
      CRV_IN_QUAD: begin
        push_ctl.op = OP_SQ;
      end
      CRV_OUT_QUAD: begin
        push_ctl.op  = OP_SQ;
        push_ctl.sub = 1'b1;
        push_x       = (F+4)'(u);
      end
      CRV_INOUT_QUAD: begin
        push_ctl.op  = OP_SQ2;
        push_ctl.sub = !low_half;
        push_x       = low_half ? (F+4)'(f_t) : (F+4)'(u);
      end
      CRV_IN_CUBIC: begin
        push_ctl.op = OP_CUBE;
      end
      CRV_OUT_CUBIC: begin
        push_ctl.op  = OP_CUBE;
        push_ctl.sub = 1'b1;
        push_x       = (F+4)'(u);
      end
      CRV_INOUT_CUBIC: begin
        push_ctl.op  = OP_CUBE4;
        push_ctl.sub = !low_half;
        push_x       = low_half ? (F+4)'(f_t) : (F+4)'(u);
      end
      CRV_BOUNCE: begin
        push_ctl.op = OP_BNC;
        push_x      = m[F+3:0];
        push_base   = seg_base;
      end
      default: begin
        push_ctl.op = OP_LIN;
      end
    endcase
  end

endmodule

// ----- rtl/ece_queue.sv -----
// Small flop-based FIFO between the front end and the back end.
module ece_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output logic [WIDTH-1:0] rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = count == CW'(DEPTH);
  assign nonempty = count != '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign rdata    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- rtl/ece_back.sv -----
// Back end: four-stage multiply/round pipeline ending in the output register.
module ece_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         nonempty,
  output logic                         pop,
  input  ece_pkg::ctl_t                pop_ctl,
  input  logic [FRAC_BITS+3:0]         pop_x,
  input  logic [FRAC_BITS:0]           pop_base,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ece_pkg::EASED_W-1:0]  eased
);
  import ece_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int XW = F + 4;
  localparam int PW = 2 * XW + 1;
  localparam int QW = 2 * F + 5;
  localparam int RW = (F + 2 > EASED_W) ? F + 2 : EASED_W;
  localparam logic [F:0]    ONE    = {1'b1, {F{1'b0}}};
  localparam logic [PW-1:0] HALF_P = PW'(1) << (F - 1);
  localparam logic [PW-1:0] RND_B  = PW'(1) << (F + 5);
  localparam logic [QW-1:0] HALF_Q = QW'(1) << (F - 1);

  logic en;

  // stage 1: x*x
  logic             s1_valid;
  ctl_t             s1_ctl;
  logic [F:0]       s1_x;
  logic [F:0]       s1_base;
  logic [2*XW-1:0]  s1_p;
  // stage 2: rounded square
  logic             s2_valid;
  ctl_t             s2_ctl;
  logic [F:0]       s2_x;
  logic [F:0]       s2_base;
  logic [F:0]       s2_v;
  logic [F:0]       v_next;
  logic [PW-1:0]    r_q;
  logic [PW-1:0]    r_q2;
  logic [PW-1:0]    r_b;
  // stage 3: square times x
  logic             s3_valid;
  ctl_t             s3_ctl;
  logic [F:0]       s3_base;
  logic [F:0]       s3_v;
  logic [2*F+1:0]   s3_p;
  // output stage
  logic [QW-1:0]    c_sum;
  logic [F:0]       fin;
  logic [F+1:0]     res;
  logic [F+1:0]     add_sum;
  logic [RW-1:0]    res_x;

  assign en  = !out_valid || !out_stall;
  assign pop = en && nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= nonempty;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctl  <= pop_ctl;
      s1_x    <= pop_x[F:0];
      s1_base <= pop_base;
      s1_p    <= pop_x * pop_x;
    end
  end

  assign r_q  = ({1'b0, s1_p} + HALF_P) >> F;
  assign r_q2 = ({s1_p, 1'b0} + HALF_P) >> F;
  assign r_b  = ({1'b0, s1_p} + RND_B) >> (F + 6);

  always_comb begin
    case (s1_ctl.op)
      OP_LIN:   v_next = s1_x;
      OP_SQ2:   v_next = r_q2[F:0];
      OP_BNC:   v_next = r_b[F:0];
      default:  v_next = r_q[F:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctl  <= s1_ctl;
      s2_x    <= s1_x;
      s2_base <= s1_base;
      s2_v    <= v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ctl  <= s2_ctl;
      s3_base <= s2_base;
      s3_v    <= s2_v;
      s3_p    <= s2_v * s2_x;
    end
  end

  always_comb begin
    if (s3_ctl.op == OP_CUBE4) begin
      c_sum = (QW'(s3_p) << 2) + HALF_Q;
    end else begin
      c_sum = QW'(s3_p) + HALF_Q;
    end
  end

  always_comb begin
    if (s3_ctl.op == OP_CUBE || s3_ctl.op == OP_CUBE4) begin
      fin = c_sum[2*F:F];
    end else begin
      fin = s3_v;
    end
    add_sum = {1'b0, fin} + {1'b0, s3_base};
    if (s3_ctl.sub) begin
      res = (fin > ONE) ? {1'b0, ONE} : {1'b0, ONE - fin};
    end else begin
      res = (add_sum > {1'b0, ONE}) ? {1'b0, ONE} : add_sum;
    end
    res_x = RW'(res);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eased <= res_x[EASED_W-1:0];
    end
  end

endmodule
